@@ rtl/core/texel_density_accumulator_assert.svh @@
// Assertion macros for the texel density accumulator.
`ifndef TEXEL_DENSITY_ACCUMULATOR_ASSERT_SVH
`define TEXEL_DENSITY_ACCUMULATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define TDA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TDA_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TDA_ASSERT(lbl, clk, rst_n, prop, msg)
`define TDA_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ rtl/core/tda_pkg.sv @@
`timescale 1ns / 1ps
package tda_pkg;
  localparam int unsigned VERTEX_DEPTH = 4096;
  localparam int unsigned VIDX_W       = $clog2(VERTEX_DEPTH);
  localparam int unsigned RAD_W        = 128;
  localparam int unsigned ROOT_W       = RAD_W / 2;
  localparam int unsigned ROOT_CNT_W   = $clog2(ROOT_W);
  localparam logic [15:0] RES_RESET    = 16'd1024;
  localparam logic        CMD_VERTEX   = 1'b0;
  localparam logic        CMD_CORNER   = 1'b1;
endpackage

@@ rtl/core/texel_density_accumulator.sv @@
`timescale 1ns / 1ps
// Texel density accumulator.
// Requests enter on start_i while busy_o is low. command_i = 0 writes a vertex
// (UV, position) into the 4096-entry vertex memory; busy_o stays low.
// command_i = 1 submits a corner index; every third corner closes a triangle.
// A closing corner reads its three vertices from the registered-read memory,
// runs the cross products and squares through one shared 33x33 multiplier and
// the length through the serial square-root unit (a 64-step root).
// The corner flagged last_corner_i emits one result on density_o / no_area_o,
// marked by result_valid_o for exactly one cycle, then clears the sums. After
// any face work it passes through the check, the 128-step divider, a root
// start, the 64-step root and three product steps, or only the check when
// no_area_o is set; result_valid_o rises as busy_o falls. The receiver cannot
// stall. texture_resolution is written on the cfg channel (always ready); the
// user must write it only while idle, the block does not enforce this.
// Reset clears the sums, corner phase and control state and sets the
// resolution to 1024; vertex memory contents stay undefined until written.
`include "texel_density_accumulator_assert.svh"
module texel_density_accumulator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        command_i,
  input  logic [tda_pkg::VIDX_W-1:0]  vertex_index_i,
  input  logic signed [15:0]          tex_u_i,
  input  logic signed [15:0]          tex_v_i,
  input  logic signed [31:0]          pos_x_i,
  input  logic signed [31:0]          pos_y_i,
  input  logic signed [31:0]          pos_z_i,
  input  logic                        last_corner_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [15:0]                 cfg_data_i,
  output logic                        result_valid_o,
  output logic [31:0]                 density_o,
  output logic                        no_area_o
);
  typedef enum logic [4:0] {
    S_IDLE, S_RD1, S_RD2, S_RD3, S_U1, S_U2, S_U3, S_U4,
    S_X1, S_X2, S_X3, S_X4, S_Q1, S_Q2, S_Q3, S_Q4,
    S_WSTART, S_WROOT, S_CHK, S_DIV, S_QSTART, S_QROOT, S_P1, S_P2, S_P3
  } state_e;

  state_e state_q;
  logic [127:0] mem_q [tda_pkg::VERTEX_DEPTH];
  logic [127:0] rd_q, v0_q, v1_q;
  logic [tda_pkg::VIDX_W-1:0] rd_addr, held0_q, held1_q, cidx_q;
  logic [1:0]  phase_q, comp_q;
  logic        last_q, face_q;
  logic [15:0] res_q;
  logic [63:0] uv_sum_q, world_sum_q, c_q, s_q;
  logic [127:0] sum_q, n_q;
  logic [63:0] rem_q;
  logic [6:0]  cnt_q;
  logic signed [16:0] du1_q, dv1_q, du2_q, dv2_q;
  logic signed [30:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q, acc_q, acc_diff;
  logic [47:0] p_lo_q;
  logic        res_valid_q, no_area_q;
  logic [31:0] density_q;
  logic        accept, sq_start, sq_done;
  logic [127:0] sq_rad;
  logic [63:0] sq_root;
  logic [64:0] rem2, uv_add, w_add;
  logic [63:0] acc_abs;
  logic [79:0] prod80;
  logic signed [32:0] dx1, dy1, dz1, dx2, dy2, dz2;

  assign accept      = start_i && state_q == S_IDLE;
  assign busy_o      = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i) begin
    if (accept && command_i == tda_pkg::CMD_VERTEX) begin
      mem_q[vertex_index_i] <= {pos_z_i, pos_y_i, pos_x_i, tex_v_i, tex_u_i};
    end
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    unique case (state_q)
      S_RD1:   rd_addr = held1_q;
      S_RD2:   rd_addr = cidx_q;
      default: rd_addr = held0_q;
    endcase
  end

  always_comb begin
    dx1 = 33'(signed'(v1_q[63:32])) - 33'(signed'(v0_q[63:32]));
    dy1 = 33'(signed'(v1_q[95:64])) - 33'(signed'(v0_q[95:64]));
    dz1 = 33'(signed'(v1_q[127:96])) - 33'(signed'(v0_q[127:96]));
    dx2 = 33'(signed'(rd_q[63:32])) - 33'(signed'(v0_q[63:32]));
    dy2 = 33'(signed'(rd_q[95:64])) - 33'(signed'(v0_q[95:64]));
    dz2 = 33'(signed'(rd_q[127:96])) - 33'(signed'(v0_q[127:96]));
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_U1: begin mul_a = 33'(du1_q); mul_b = 33'(dv2_q); end
      S_U2: begin mul_a = 33'(du2_q); mul_b = 33'(dv1_q); end
      S_X1: begin
        unique case (comp_q)
          2'd0:    begin mul_a = 33'(ay_q); mul_b = 33'(bz_q); end
          2'd1:    begin mul_a = 33'(az_q); mul_b = 33'(bx_q); end
          default: begin mul_a = 33'(ax_q); mul_b = 33'(by_q); end
        endcase
      end
      S_X2: begin
        unique case (comp_q)
          2'd0:    begin mul_a = 33'(az_q); mul_b = 33'(by_q); end
          2'd1:    begin mul_a = 33'(ax_q); mul_b = 33'(bz_q); end
          default: begin mul_a = 33'(ay_q); mul_b = 33'(bx_q); end
        endcase
      end
      S_Q1: begin mul_a = {1'b0, c_q[31:0]};  mul_b = {1'b0, c_q[31:0]}; end
      S_Q2: begin mul_a = {1'b0, c_q[63:32]}; mul_b = {1'b0, c_q[31:0]}; end
      S_Q3: begin mul_a = {1'b0, c_q[63:32]}; mul_b = {1'b0, c_q[63:32]}; end
      S_P1: begin mul_a = {1'b0, s_q[31:0]};  mul_b = {17'd0, res_q}; end
      S_P2: begin mul_a = {1'b0, s_q[63:32]}; mul_b = {17'd0, res_q}; end
      default: ;
    endcase
  end

  always_comb begin
    acc_diff = acc_q - prod_q;
    acc_abs  = acc_q[65] ? 64'(-acc_q) : acc_q[63:0];
    uv_add   = {1'b0, uv_sum_q} + {1'b0, acc_abs};
    w_add    = {1'b0, world_sum_q} + {1'b0, sq_root};
    rem2     = {rem_q, n_q[127]};
    prod80   = {32'd0, p_lo_q} + {prod_q[47:0], 32'd0};
    sq_start = state_q == S_WSTART || state_q == S_QSTART;
    sq_rad   = (state_q == S_WSTART) ? sum_q : n_q;
  end

  tda_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sq_rad),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= '0;
      held0_q     <= '0;
      held1_q     <= '0;
      uv_sum_q    <= '0;
      world_sum_q <= '0;
      face_q      <= 1'b0;
      last_q      <= 1'b0;
      res_q       <= tda_pkg::RES_RESET;
      res_valid_q <= 1'b0;
      comp_q      <= '0;
      cnt_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        res_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && command_i == tda_pkg::CMD_CORNER) begin
            last_q <= last_corner_i;
            cidx_q <= vertex_index_i;
            if (phase_q == 2'd2) begin
              phase_q <= '0;
              state_q <= S_RD1;
            end else begin
              if (phase_q == 2'd0) held0_q <= vertex_index_i;
              else held1_q <= vertex_index_i;
              phase_q <= phase_q + 1'b1;
              if (last_corner_i) state_q <= S_CHK;
            end
          end
        end
        S_RD1: begin v0_q <= rd_q; state_q <= S_RD2; end
        S_RD2: begin v1_q <= rd_q; state_q <= S_RD3; end
        S_RD3: begin
          du1_q <= 17'(signed'(v1_q[15:0])) - 17'(signed'(v0_q[15:0]));
          dv1_q <= 17'(signed'(v1_q[31:16])) - 17'(signed'(v0_q[31:16]));
          du2_q <= 17'(signed'(rd_q[15:0])) - 17'(signed'(v0_q[15:0]));
          dv2_q <= 17'(signed'(rd_q[31:16])) - 17'(signed'(v0_q[31:16]));
          ax_q  <= dx1[32:2];
          ay_q  <= dy1[32:2];
          az_q  <= dz1[32:2];
          bx_q  <= dx2[32:2];
          by_q  <= dy2[32:2];
          bz_q  <= dz2[32:2];
          state_q <= S_U1;
        end
        S_U1: state_q <= S_U2;
        S_U2: begin acc_q <= prod_q; state_q <= S_U3; end
        S_U3: begin acc_q <= acc_diff; state_q <= S_U4; end
        S_U4: begin
          uv_sum_q <= uv_add[64] ? '1 : uv_add[63:0];
          sum_q    <= '0;
          comp_q   <= '0;
          state_q  <= S_X1;
        end
        S_X1: state_q <= S_X2;
        S_X2: begin acc_q <= prod_q; state_q <= S_X3; end
        S_X3: begin acc_q <= acc_diff; state_q <= S_X4; end
        S_X4: begin c_q <= acc_abs; state_q <= S_Q1; end
        S_Q1: state_q <= S_Q2;
        S_Q2: begin sum_q <= sum_q + {64'd0, prod_q[63:0]}; state_q <= S_Q3; end
        S_Q3: begin sum_q <= sum_q + {31'd0, prod_q[63:0], 33'd0}; state_q <= S_Q4; end
        S_Q4: begin
          sum_q <= sum_q + {prod_q[63:0], 64'd0};
          if (comp_q == 2'd2) begin
            state_q <= S_WSTART;
          end else begin
            comp_q  <= comp_q + 1'b1;
            state_q <= S_X1;
          end
        end
        S_WSTART: state_q <= S_WROOT;
        S_WROOT: begin
          if (sq_done) begin
            world_sum_q <= w_add[64] ? '1 : w_add[63:0];
            face_q      <= 1'b1;
            state_q     <= last_q ? S_CHK : S_IDLE;
          end
        end
        S_CHK: begin
          if (!face_q || world_sum_q == '0 || res_q == '0) begin
            density_q   <= '0;
            no_area_q   <= 1'b1;
            res_valid_q <= 1'b1;
            phase_q     <= '0;
            held0_q     <= '0;
            held1_q     <= '0;
            uv_sum_q    <= '0;
            world_sum_q <= '0;
            face_q      <= 1'b0;
            state_q     <= S_IDLE;
          end else begin
            n_q     <= {4'd0, uv_sum_q, 60'd0};
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem2 >= {1'b0, world_sum_q}) begin
            rem_q <= 64'(rem2 - {1'b0, world_sum_q});
            n_q   <= {n_q[126:0], 1'b1};
          end else begin
            rem_q <= rem2[63:0];
            n_q   <= {n_q[126:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 7'd127) state_q <= S_QSTART;
        end
        S_QSTART: state_q <= S_QROOT;
        S_QROOT: begin
          if (sq_done) begin
            s_q     <= sq_root;
            state_q <= S_P1;
          end
        end
        S_P1: state_q <= S_P2;
        S_P2: begin p_lo_q <= prod_q[47:0]; state_q <= S_P3; end
        S_P3: begin
          density_q   <= (prod80[79:44] != '0) ? '1 : prod80[43:12];
          no_area_q   <= 1'b0;
          res_valid_q <= 1'b1;
          phase_q     <= '0;
          held0_q     <= '0;
          held1_q     <= '0;
          uv_sum_q    <= '0;
          world_sum_q <= '0;
          face_q      <= 1'b0;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign density_o      = density_q;
  assign no_area_o      = no_area_q;

  `TDA_ASSERT(a_no_area_zero, clk_i, rst_ni,
              (result_valid_o && no_area_o) |-> (density_o == '0), "no_area with density")
  `TDA_ASSERT(a_busy_cause, clk_i, rst_ni,
              $rose(busy_o) |-> $past(start_i && command_i == tda_pkg::CMD_CORNER),
              "busy without corner request")
  `TDA_NEVER(a_root_wait, clk_i, rst_ni,
             sq_done && state_q != S_WROOT && state_q != S_QROOT, "root done outside wait")
endmodule

@@ rtl/core/tda_sqrt.sv @@
`timescale 1ns / 1ps
// Bit-serial integer square root, two radicand bits per cycle.
module tda_sqrt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [tda_pkg::RAD_W-1:0]        radicand_i,
  output logic                             done_o,
  output logic [tda_pkg::ROOT_W-1:0]       root_o
);
  logic [tda_pkg::RAD_W-1:0]      x_q;
  logic [tda_pkg::ROOT_W+2:0]     rem_q;
  logic [tda_pkg::ROOT_W-1:0]     root_q;
  logic [tda_pkg::ROOT_CNT_W-1:0] cnt_q;
  logic                           active_q, done_q;
  logic [tda_pkg::ROOT_W+2:0]     rem2, trial;
  logic                           take;

  always_comb begin
    rem2  = {rem_q[tda_pkg::ROOT_W:0], x_q[tda_pkg::RAD_W-1 -: 2]};
    trial = {1'b0, root_q, 2'b01};
    take  = rem2 >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == tda_pkg::ROOT_CNT_W'(tda_pkg::ROOT_W - 1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (active_q) begin
      x_q    <= {x_q[tda_pkg::RAD_W-3:0], 2'b00};
      rem_q  <= take ? rem2 - trial : rem2;
      root_q <= {root_q[tda_pkg::ROOT_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule
